// ===== src/orot_pkg.sv =====
// Package for the oriented rectangle overlap test.
// Holds the fixed field width, corner counts, mode codes and the stage-enable struct.
// No dependencies.
`default_nettype none

package orot_pkg;

  localparam int FIELD_W     = 16;
  localparam int NUM_CORNERS = 4;
  localparam int NUM_AXES    = 4;
  localparam int NUM_COORDS  = 2 * NUM_CORNERS;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TEST = 1'b1;

  // Clock enables for the lane pipeline stages, driven by the top level.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } lane_ce_t;

endpackage

`default_nettype wire

// ===== src/orot_lane.sv =====
// One axis lane: projects all eight corners onto one axis and checks interval overlap.
// Depends on orot_pkg for corner counts and the stage-enable struct.
`default_nettype none

module orot_lane #(
  parameter int CV = 16
) (
  input  logic                                          clk,
  input  orot_pkg::lane_ce_t                            ce,
  input  logic [orot_pkg::NUM_COORDS-1:0][CV-1:0]       a_pts,
  input  logic [orot_pkg::NUM_COORDS-1:0][CV-1:0]       b_pts,
  input  logic [CV:0]                                   ax,
  input  logic [CV:0]                                   ay,
  output logic                                          overlap
);
  import orot_pkg::*;

  localparam int PRW = 2 * CV + 1;
  localparam int PW  = 2 * CV + 2;
  localparam int NP  = 2 * NUM_CORNERS;

  function automatic logic signed [PW-1:0] smin(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [PW-1:0] smax(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic signed [CV-1:0]  px [NP];
  logic signed [CV-1:0]  py [NP];
  logic signed [PRW-1:0] prod_x_r [NP];
  logic signed [PRW-1:0] prod_y_r [NP];
  logic signed [PW-1:0]  proj_r [NP];
  logic signed [PW-1:0]  lo_a_r, hi_a_r, lo_b_r, hi_b_r;
  logic signed [PW-1:0]  lo_a, hi_a, lo_b, hi_b;
  logic                  overlap_r;

  // Points 0..3 are the reference corners, 4..7 the test corners.
  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      px[k]               = a_pts[2*k];
      py[k]               = a_pts[2*k+1];
      px[k + NUM_CORNERS] = b_pts[2*k];
      py[k + NUM_CORNERS] = b_pts[2*k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce.s2) begin
      for (int p = 0; p < NP; p++) begin
        prod_x_r[p] <= px[p] * $signed(ax);
        prod_y_r[p] <= py[p] * $signed(ay);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce.s3) begin
      for (int p = 0; p < NP; p++) begin
        proj_r[p] <= {prod_x_r[p][PRW-1], prod_x_r[p]} + {prod_y_r[p][PRW-1], prod_y_r[p]};
      end
    end
  end

  always_comb begin
    lo_a = smin(smin(proj_r[0], proj_r[1]), smin(proj_r[2], proj_r[3]));
    hi_a = smax(smax(proj_r[0], proj_r[1]), smax(proj_r[2], proj_r[3]));
    lo_b = smin(smin(proj_r[4], proj_r[5]), smin(proj_r[6], proj_r[7]));
    hi_b = smax(smax(proj_r[4], proj_r[5]), smax(proj_r[6], proj_r[7]));
  end

  always_ff @(posedge clk) begin
    if (ce.s4) begin
      lo_a_r <= lo_a;
      hi_a_r <= hi_a;
      lo_b_r <= lo_b;
      hi_b_r <= hi_b;
    end
  end

  // Touching end points count as overlap.
  always_ff @(posedge clk) begin
    if (ce.s5) begin
      overlap_r <= (lo_b_r <= hi_a_r) && (hi_b_r >= lo_a_r);
    end
  end

  assign overlap = overlap_r;

endmodule

`default_nettype wire

// ===== src/oriented_rect_overlap_test.sv =====
// Top level of the oriented rectangle overlap test (2D separating axis theorem).
// Depends on orot_pkg and orot_lane.
//
// Usage: the input channel carries one word per rectangle: a mode bit and four
// corners in signed fixed point. A word with mode load replaces the stored
// reference rectangle and produces no result. A word with mode test is checked
// against the reference that is stored at the moment it is accepted, and
// produces exactly one result word whose collide bit is 1 when the intervals
// overlap on all four axes.
// Throughput is one word per cycle while out_ready does not hold the output back:
// every stage of the pipeline is a register, and four axis lanes run side by side,
// each with its own sixteen multipliers. From the accepting edge to out_valid a
// word passes the input and axis stage, which loads at that edge, then the
// product stage, projection stage, min/max stage, overlap compare and the output
// register where the lane results are merged.
// When the receiver holds out_ready low, the result waits in the output register
// and the pipeline keeps accepting words until every stage holds a valid word;
// bubbles are squeezed out first. Reset clears all valid bits and sets the
// reference rectangle to a single point at the origin.
`default_nettype none

module oriented_rect_overlap_test #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner0_x,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner0_y,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner1_x,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner1_y,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner2_x,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner2_y,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner3_x,
  input  logic signed [orot_pkg::FIELD_W-1:0] in_corner3_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_collide
);
  import orot_pkg::*;

  // Internal coordinate width: a field is sign-extended from its low COORD_WIDTH
  // bits when COORD_WIDTH is at most 16, otherwise it is taken as non-negative.
  localparam int CV     = (COORD_WIDTH <= FIELD_W) ? COORD_WIDTH : FIELD_W + 1;
  localparam int AW     = CV + 1;
  localparam int NSTAGE = 5;

  logic [FIELD_W-1:0] ref_r [NUM_COORDS];
  logic [FIELD_W-1:0] raw   [2*NUM_COORDS];
  logic [CV-1:0]      cval  [2*NUM_COORDS];

  logic [NUM_COORDS-1:0][CV-1:0] a_r, b_r;
  logic [NUM_AXES-1:0][AW-1:0]   axx_r, axy_r;
  logic [NUM_AXES-1:0][AW-1:0]   axx, axy;

  logic [NSTAGE-1:0] vld_r, vld_nxt, ce;
  logic              ce_out;
  logic              out_valid_r, out_valid_nxt;
  logic              out_collide_r;
  logic [NUM_AXES-1:0] lane_ovl;
  lane_ce_t          lane_ce;
  logic              in_acc;

  function automatic logic [AW-1:0] sext(input logic [CV-1:0] v);
    return {v[CV-1], v};
  endfunction

  // Raw coordinates: entries 0..7 are the stored reference, 8..15 the incoming word.
  always_comb begin
    for (int i = 0; i < NUM_COORDS; i++) begin
      raw[i] = ref_r[i];
    end
    raw[NUM_COORDS+0] = in_corner0_x;
    raw[NUM_COORDS+1] = in_corner0_y;
    raw[NUM_COORDS+2] = in_corner1_x;
    raw[NUM_COORDS+3] = in_corner1_y;
    raw[NUM_COORDS+4] = in_corner2_x;
    raw[NUM_COORDS+5] = in_corner2_y;
    raw[NUM_COORDS+6] = in_corner3_x;
    raw[NUM_COORDS+7] = in_corner3_y;
  end

  for (genvar g = 0; g < 2 * NUM_COORDS; g++) begin : g_coord
    if (COORD_WIDTH <= FIELD_W) begin : g_narrow
      assign cval[g] = raw[g][CV-1:0];
    end else begin : g_wide
      assign cval[g] = {1'b0, raw[g]};
    end
  end

  // Axes: reference c1-c0, reference c1-c2, test c0-c3, test c0-c1.
  always_comb begin
    axx[0] = sext(cval[2]) - sext(cval[0]);
    axy[0] = sext(cval[3]) - sext(cval[1]);
    axx[1] = sext(cval[2]) - sext(cval[4]);
    axy[1] = sext(cval[3]) - sext(cval[5]);
    axx[2] = sext(cval[NUM_COORDS+0]) - sext(cval[NUM_COORDS+6]);
    axy[2] = sext(cval[NUM_COORDS+1]) - sext(cval[NUM_COORDS+7]);
    axx[3] = sext(cval[NUM_COORDS+0]) - sext(cval[NUM_COORDS+2]);
    axy[3] = sext(cval[NUM_COORDS+1]) - sext(cval[NUM_COORDS+3]);
  end

  // Stage enables: a stage loads when it is empty or its successor moves on.
  always_comb begin
    ce_out            = !out_valid_r || out_ready;
    ce[NSTAGE-1]      = !vld_r[NSTAGE-1] || ce_out;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      ce[k] = !vld_r[k] || ce[k+1];
    end
    vld_nxt[0] = ce[0] ? (in_valid && (in_mode == MODE_TEST)) : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = ce[k] ? vld_r[k-1] : vld_r[k];
    end
    out_valid_nxt = ce_out ? vld_r[NSTAGE-1] : out_valid_r;
  end

  assign in_ready = ce[0];
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A load word replaces the reference; test words already in flight keep
  // the coordinates and axes they captured on acceptance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        ref_r[i] <= '0;
      end
    end else if (in_acc && (in_mode == MODE_LOAD)) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        ref_r[i] <= raw[NUM_COORDS+i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        a_r[i] <= cval[i];
        b_r[i] <= cval[NUM_COORDS+i];
      end
      axx_r <= axx;
      axy_r <= axy;
    end
  end

  assign lane_ce = '{s2: ce[1], s3: ce[2], s4: ce[3], s5: ce[4]};

  for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
    orot_lane #(.CV(CV)) u_lane (
      .clk     (clk),
      .ce      (lane_ce),
      .a_pts   (a_r),
      .b_pts   (b_r),
      .ax      (axx_r[l]),
      .ay      (axy_r[l]),
      .overlap (lane_ovl[l])
    );
  end

  // Merge: any separating axis means no collision.
  always_ff @(posedge clk) begin
    if (ce_out) begin
      out_collide_r <= &lane_ovl;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_collide = out_collide_r;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the oriented rectangle overlap test block.
// Depends on orot_pkg and oriented_rect_overlap_test; a scoreboard class predicts collide
// with an exact separating axis check and compares every result word in order.
`timescale 1ns / 1ps

module tb;

  import orot_pkg::*;

  // One rectangle as it appears on the input channel: four corners, raw 16-bit fields.
  typedef struct packed {
    logic [NUM_CORNERS-1:0][FIELD_W-1:0] x;
    logic [NUM_CORNERS-1:0][FIELD_W-1:0] y;
  } rect_t;

  // Holds a private copy of the stored reference rectangle and the queue of collide
  // bits still owed by the block. A load word replaces the reference. A test word is
  // resolved against the reference as it stands at acceptance, so predictions are made
  // in acceptance order and consumed in the same order.
  class overlap_board;
    rect_t ref_rect;
    bit    collide_q[$];
    int    errors;
    int    loads;
    int    tests;
    int    hits;
    int    misses;

    function new();
      ref_rect = '0;
      errors   = 0;
      loads    = 0;
      tests    = 0;
      hits     = 0;
      misses   = 0;
    endfunction

    function longint cx(rect_t r, int k);
      return longint'($signed(r.x[k]));
    endfunction

    function longint cy(rect_t r, int k);
      return longint'($signed(r.y[k]));
    endfunction

    // Exact projection interval of all four corners onto one axis.
    function void interval(rect_t r, longint ax, longint ay,
                           output longint lo, output longint hi);
      longint p;
      lo = cx(r, 0) * ax + cy(r, 0) * ay;
      hi = lo;
      for (int k = 1; k < NUM_CORNERS; k++) begin
        p = cx(r, k) * ax + cy(r, k) * ay;
        if (p < lo) lo = p;
        if (p > hi) hi = p;
      end
    endfunction

    // Reference edges c1-c0, c1-c2 and test edges c0-c3, c0-c1 serve as axes.
    // Touching end points count as overlap, and a zero-length axis projects
    // everything to zero, so it can never separate.
    function bit sat_collide(rect_t t);
      longint ax [NUM_AXES];
      longint ay [NUM_AXES];
      longint lo_r, hi_r, lo_t, hi_t;
      bit     hit;
      ax[0] = cx(ref_rect, 1) - cx(ref_rect, 0);
      ay[0] = cy(ref_rect, 1) - cy(ref_rect, 0);
      ax[1] = cx(ref_rect, 1) - cx(ref_rect, 2);
      ay[1] = cy(ref_rect, 1) - cy(ref_rect, 2);
      ax[2] = cx(t, 0) - cx(t, 3);
      ay[2] = cy(t, 0) - cy(t, 3);
      ax[3] = cx(t, 0) - cx(t, 1);
      ay[3] = cy(t, 0) - cy(t, 1);
      hit = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
        interval(ref_rect, ax[i], ay[i], lo_r, hi_r);
        interval(t, ax[i], ay[i], lo_t, hi_t);
        if (!(lo_t <= hi_r && hi_t >= lo_r)) hit = 1'b0;
      end
      return hit;
    endfunction

    function void note_word(logic mode, rect_t r);
      if (mode == MODE_LOAD) begin
        ref_rect = r;
        loads++;
      end else begin
        collide_q.push_back(sat_collide(r));
        tests++;
      end
    endfunction

    function void check_result(logic collide);
      bit want;
      if (collide_q.size() == 0) begin
        $display("%0t: result word collide=%0b arrived with no test word pending",
                 $time, collide);
        errors++;
        return;
      end
      want = collide_q.pop_front();
      if (collide !== want) begin
        $display("%0t: collide mismatch, expected %0b, actual %0b", $time, want, collide);
        errors++;
      end else if (want) begin
        hits++;
      end else begin
        misses++;
      end
    endfunction

    function int pending();
      return collide_q.size();
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_WORDS    = 360;
  localparam int TAIL_CYCLES    = 12;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid     = 1'b0;
  logic                      in_ready;
  logic                      in_mode      = MODE_LOAD;
  logic signed [FIELD_W-1:0] in_corner0_x = '0;
  logic signed [FIELD_W-1:0] in_corner0_y = '0;
  logic signed [FIELD_W-1:0] in_corner1_x = '0;
  logic signed [FIELD_W-1:0] in_corner1_y = '0;
  logic signed [FIELD_W-1:0] in_corner2_x = '0;
  logic signed [FIELD_W-1:0] in_corner2_y = '0;
  logic signed [FIELD_W-1:0] in_corner3_x = '0;
  logic signed [FIELD_W-1:0] in_corner3_y = '0;
  logic                      out_valid;
  logic                      out_ready    = 1'b0;
  logic                      out_collide;

  // Percent of cycles in which the sender holds back a word and the receiver stalls.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Handshake pressure per random phase: none, sender idle, receiver stall, both light.
  int idle_tab  [4] = '{0, 81, 0, 11};
  int stall_tab [4] = '{0, 0, 81, 11};

  int idle_cycles = 0;

  overlap_board board;

  oriented_rect_overlap_test dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_corner0_x (in_corner0_x),
    .in_corner0_y (in_corner0_y),
    .in_corner1_x (in_corner1_x),
    .in_corner1_y (in_corner1_y),
    .in_corner2_x (in_corner2_x),
    .in_corner2_y (in_corner2_y),
    .in_corner3_x (in_corner3_x),
    .in_corner3_y (in_corner3_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_collide  (out_collide)
  );

  always #6 clk = ~clk;

  // The receiver decides its ready for the next edge at every falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are observed at the rising edge, before the block's registers move.
  // A test word cannot return in its own cycle, so noting before checking is safe.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      board.note_word(in_mode, '{x: {in_corner3_x, in_corner2_x, in_corner1_x, in_corner0_x},
                                 y: {in_corner3_y, in_corner2_y, in_corner1_y, in_corner0_y}});
    end
    if (rst_n && out_valid && out_ready) begin
      board.check_result(out_collide);
    end
  end

  // Watchdog: any long stretch in which neither channel moves a word ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d results still owed",
               $time, WATCHDOG_LIMIT, board.pending());
      $display("tb: errors");
      $finish;
    end
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int mag(int v);
    return (v < 0) ? -v : v;
  endfunction

  // Axis-aligned box ordered so that the block's two reference axes and two test
  // axes come out as one vertical and one horizontal edge.
  function automatic rect_t box(int l, int b, int r, int t);
    rect_t q;
    q.x[0] = FIELD_W'(r); q.y[0] = FIELD_W'(t);
    q.x[1] = FIELD_W'(r); q.y[1] = FIELD_W'(b);
    q.x[2] = FIELD_W'(l); q.y[2] = FIELD_W'(b);
    q.x[3] = FIELD_W'(l); q.y[3] = FIELD_W'(t);
    return q;
  endfunction

  // Rotated rectangle around (cx, cy): half edges U = s1*(ua, ub) and V = s2*(-ub, ua)
  // are perpendicular, so integer corners describe a true rectangle at any angle.
  function automatic rect_t oriented(int cx, int cy, int ua, int ub, int s1, int s2);
    rect_t q;
    int    ux, uy, vx, vy;
    ux = ua * s1;  uy = ub * s1;
    vx = -ub * s2; vy = ua * s2;
    q.x[0] = FIELD_W'(cx + ux + vx); q.y[0] = FIELD_W'(cy + uy + vy);
    q.x[1] = FIELD_W'(cx + ux - vx); q.y[1] = FIELD_W'(cy + uy - vy);
    q.x[2] = FIELD_W'(cx - ux - vx); q.y[2] = FIELD_W'(cy - uy - vy);
    q.x[3] = FIELD_W'(cx - ux + vx); q.y[3] = FIELD_W'(cy - uy + vy);
    return q;
  endfunction

  // Presents one word at a falling edge, after a random number of idle cycles, and
  // returns at the falling edge after it was taken. Valid stays high into the next
  // word unless the sender decides to idle there.
  task automatic send_word(input logic mode, input rect_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_corner0_x <= r.x[0];
    in_corner0_y <= r.y[0];
    in_corner1_x <= r.x[1];
    in_corner1_y <= r.y[1];
    in_corner2_x <= r.x[2];
    in_corner2_y <= r.y[2];
    in_corner3_x <= r.x[3];
    in_corner3_y <= r.y[3];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    rect_t q;
    int    roll;
    int    cx, cy, ua, ub, s1, s2, off, reach;
    int    ref_cx, ref_cy, ref_reach;
    int    tail;

    board     = new();
    ref_cx    = 0;
    ref_cy    = 0;
    ref_reach = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, run without any idling.
    // Before any load the reference is a single point at the origin.
    send_word(MODE_TEST, box(-16, -16, 16, 16));
    send_word(MODE_TEST, box(100, 100, 200, 200));
    send_word(MODE_TEST, box(0, 0, 0, 0));

    // Full-scale reference against full-scale and single-corner test rectangles.
    send_word(MODE_LOAD, box(-32768, -32768, 32767, 32767));
    send_word(MODE_TEST, box(-32768, -32768, 32767, 32767));
    send_word(MODE_TEST, box(32767, 32767, 32767, 32767));
    send_word(MODE_TEST, box(-32768, -32768, -32768, -32768));
    send_word(MODE_TEST, box(-1, -1, -1, -1));

    // Touching intervals overlap, a gap of one LSB separates.
    send_word(MODE_LOAD, box(0, 0, 160, 160));
    send_word(MODE_TEST, box(160, 0, 320, 160));
    send_word(MODE_TEST, box(161, 0, 320, 160));
    send_word(MODE_TEST, box(160, 160, 300, 300));
    send_word(MODE_TEST, box(-100, -100, -1, -1));
    send_word(MODE_TEST, oriented(80, 80, 1, 1, 40, 40));
    // A diamond off the box corner is only separated by one of its own diagonal axes.
    send_word(MODE_TEST, oriented(200, 200, 1, 1, 20, 20));

    // Reference with a zero-length first edge: that axis can never separate.
    q = box(0, 0, 160, 160);
    q.x[1] = q.x[0];
    q.y[1] = q.y[0];
    send_word(MODE_LOAD, q);
    send_word(MODE_TEST, box(500, 500, 600, 600));
    send_word(MODE_TEST, box(50, 50, 50, 50));

    // Unordered corners are taken as given.
    q = box(0, 0, 100, 40);
    q.x[1] = 0; q.y[1] = 0;
    q.x[2] = 100; q.y[2] = 40;
    send_word(MODE_LOAD, q);
    send_word(MODE_TEST, q);
    send_word(MODE_TEST, box(200, -300, 260, -200));
    send_word(MODE_TEST, box(0, 0, 0, 0));

    // Random part: four pressure phases. Most words are true rectangles placed near
    // the current reference so that both outcomes are common; the rest are raw noise
    // and full-scale corner values with a random mode.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      repeat (PHASE_WORDS) begin
        roll = $urandom_range(99);
        ua   = pick(-48, 48);
        ub   = pick(-48, 48);
        s1   = pick(0, 48);
        s2   = pick(0, 48);
        reach = mag(ua) * s1 + mag(ub) * s1 + mag(ua) * s2 + mag(ub) * s2;
        if (roll < 18) begin
          cx = pick(-10000, 10000);
          cy = pick(-10000, 10000);
          send_word(MODE_LOAD, oriented(cx, cy, ua, ub, s1, s2));
          ref_cx    = cx;
          ref_cy    = cy;
          ref_reach = reach;
        end else if (roll < 85) begin
          off = (ref_reach + reach) / 2 + 64;
          cx  = ref_cx + pick(-off, off);
          cy  = ref_cy + pick(-off, off);
          send_word(MODE_TEST, oriented(cx, cy, ua, ub, s1, s2));
        end else if (roll < 95) begin
          for (int k = 0; k < NUM_CORNERS; k++) begin
            q.x[k] = FIELD_W'($urandom());
            q.y[k] = FIELD_W'($urandom());
          end
          send_word(logic'($urandom_range(1)), q);
        end else begin
          for (int k = 0; k < 2 * NUM_CORNERS; k++) begin
            case ($urandom_range(3))
              0:       q[k*FIELD_W +: FIELD_W] = 16'h8000;
              1:       q[k*FIELD_W +: FIELD_W] = 16'h7fff;
              2:       q[k*FIELD_W +: FIELD_W] = 16'h0000;
              default: q[k*FIELD_W +: FIELD_W] = 16'hffff;
            endcase
          end
          send_word(logic'($urandom_range(1)), q);
        end
      end
    end

    in_valid <= 1'b0;

    // Drain: the watchdog bounds this wait, then give the pipeline a few more cycles
    // so that any stray result word would still be caught.
    while (board.pending() != 0) @(posedge clk);
    tail = 0;
    while (tail < TAIL_CYCLES) begin
      @(posedge clk);
      tail++;
    end

    $display("Run covered %0d reference loads and %0d test words (%0d overlapping, %0d apart)",
             board.loads, board.tests, board.hits, board.misses);
    $display("under no idling, sender gaps, receiver stalls and both at once.");
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== oriented_rect_overlap_test.f =====
src/orot_pkg.sv
src/orot_lane.sv
src/oriented_rect_overlap_test.sv
tb/tb.sv
